### rtl/mbd_pkg.sv
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int NUM_BUTTONS = 16;

    localparam int RAW_W    = 64;
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 4;
    localparam int OFFSET_W = 6;
    localparam int HIST_W   = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;

    // input tdata: raw_bits, now_ms, button_index, hold_duration,
    // clear_pressed, clear_released (lowest first), padded to bytes
    localparam int S_FIELDS_W = RAW_W + TIME_W + IDX_W + TIME_W + 2;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // result tdata: pressed_event, released_event, held, held_long_enough,
    // hold_time_ms (lowest first), padded to bytes
    localparam int M_FIELDS_W = 4 + TIME_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [HIST_W-1:0] HIST_ONES  = 8'hFF;
    localparam logic [HIST_W-1:0] HIST_ZEROS = 8'h00;

    typedef enum logic {
        OP_SCAN  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LOW = 1'b0,
        REG_BIT_OFFSET = 1'b1
    } cfg_reg_t;

    // per-lane controls driven from the top level
    typedef struct packed {
        logic              init;
        logic              active_low;
        logic              scan_en;
        logic              sample;
        logic [TIME_W-1:0] now_ms;
        logic              clr_press;
        logic              clr_release;
    } lane_ctrl_t;

    // per-lane state seen by the merge stage
    typedef struct packed {
        logic              press_flag;
        logic              release_flag;
        logic              held;
        logic [TIME_W-1:0] press_time;
    } lane_stat_t;

    typedef struct packed {
        logic [TIME_W-1:0] hold_time_ms;
        logic              held_long_enough;
        logic              held;
        logic              released_event;
        logic              pressed_event;
    } result_t;

endpackage

### rtl/mbd_lane.sv
`timescale 1ns / 1ps

module mbd_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  mbd_pkg::lane_ctrl_t ctrl,
    output mbd_pkg::lane_stat_t stat
);

    logic [mbd_pkg::HIST_W-1:0] hist_reg, hist_next;
    logic                       held_reg, held_next;
    logic                       press_reg, press_next;
    logic                       release_reg, release_next;
    logic [mbd_pkg::TIME_W-1:0] ts_reg, ts_next;
    logic [mbd_pkg::HIST_W-1:0] shifted;
    logic                       now_held;

    always_comb begin
        shifted  = {hist_reg[mbd_pkg::HIST_W-2:0], ctrl.sample};
        now_held = ctrl.active_low ? (shifted == mbd_pkg::HIST_ZEROS)
                                   : (shifted == mbd_pkg::HIST_ONES);

        hist_next    = hist_reg;
        held_next    = held_reg;
        press_next   = press_reg;
        release_next = release_reg;
        ts_next      = ts_reg;

        if (ctrl.init) begin
            hist_next    = ctrl.active_low ? mbd_pkg::HIST_ONES : mbd_pkg::HIST_ZEROS;
            held_next    = 1'b0;
            press_next   = 1'b0;
            release_next = 1'b0;
            ts_next      = '0;
        end else if (ctrl.scan_en) begin
            hist_next = shifted;
            held_next = now_held;
            if (now_held && !held_reg) begin
                press_next = 1'b1;
                ts_next    = ctrl.now_ms;
            end
            if (!now_held && held_reg) begin
                release_next = 1'b1;
            end
        end else begin
            if (ctrl.clr_press) begin
                press_next = 1'b0;
            end
            if (ctrl.clr_release) begin
                release_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg    <= mbd_pkg::HIST_ONES;
            held_reg    <= 1'b0;
            press_reg   <= 1'b0;
            release_reg <= 1'b0;
            ts_reg      <= '0;
        end else begin
            hist_reg    <= hist_next;
            held_reg    <= held_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            ts_reg      <= ts_next;
        end
    end

    assign stat.press_flag   = press_reg;
    assign stat.release_flag = release_reg;
    assign stat.held         = held_reg;
    assign stat.press_time   = ts_reg;

endmodule

### rtl/mbd_merge.sv
`timescale 1ns / 1ps

module mbd_merge (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mbd_pkg::lane_stat_t          stat [mbd_pkg::NUM_BUTTONS],
    input  logic                         query_fire,
    input  logic [mbd_pkg::IDX_W-1:0]    button_index,
    input  logic [mbd_pkg::TIME_W-1:0]   now_ms,
    input  logic [mbd_pkg::TIME_W-1:0]   hold_duration,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output mbd_pkg::result_t             out_result
);

    mbd_pkg::lane_stat_t        pick;
    mbd_pkg::result_t           res;
    logic [mbd_pkg::TIME_W-1:0] hold;

    mbd_pkg::result_t out_reg, out_next;
    mbd_pkg::result_t skid_reg, skid_next;
    logic             out_v_reg, out_v_next;
    logic             skid_v_reg, skid_v_next;

    // select the queried lane; a missing button reads as all zeros
    always_comb begin
        pick = '0;
        for (int k = 0; k < mbd_pkg::NUM_BUTTONS; k++) begin
            if (32'(k) == {{(32 - mbd_pkg::IDX_W){1'b0}}, button_index}) begin
                pick = stat[k];
            end
        end
        hold                 = pick.held ? (now_ms - pick.press_time) : '0;
        res.pressed_event    = pick.press_flag;
        res.released_event   = pick.release_flag;
        res.held             = pick.held;
        res.held_long_enough = pick.held && (hold >= hold_duration);
        res.hold_time_ms     = hold;
    end

    // output register with one skid entry behind it
    always_comb begin
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        skid_next   = skid_reg;
        skid_v_next = skid_v_reg;
        if (!out_v_reg || out_ready) begin
            if (skid_v_reg) begin
                out_next    = skid_reg;
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end else begin
                out_next   = res;
                out_v_next = query_fire;
            end
        end else if (query_fire) begin
            skid_next   = res;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_ready   = !skid_v_reg;
    assign out_valid  = out_v_reg;
    assign out_result = out_reg;

endmodule

### rtl/multi_button_debouncer.sv
`timescale 1ns / 1ps
// Queries: each result is registered in the output register, or in the skid entry while the output stalls.
// Scans produce no result; their state update is visible to the next item.
// Throughput: one item per cycle; s_tready drops only while two results wait.
// Reset (aresetn low, synchronous): active_low = 1, bit_offset = 0, all
// histories 0xFF, all flags, states and press times cleared, no result held.

module multi_button_debouncer (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_data,

    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: raw_bits[63:0], now_ms[95:64], button_index[99:96],
    //        hold_duration[131:100], clear_pressed[132], clear_released[133],
    //        zero pad[135:134]
    input  logic [mbd_pkg::S_TDATA_W-1:0]   s_tdata,
    // tuser: operation (0 scan, 1 query)
    input  logic                            s_tuser,

    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: pressed_event[0], released_event[1], held[2],
    //        held_long_enough[3], hold_time_ms[35:4], zero pad[39:36]
    output logic [mbd_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int NOW_LO = mbd_pkg::RAW_W;
    localparam int IDX_LO = NOW_LO + mbd_pkg::TIME_W;
    localparam int DUR_LO = IDX_LO + mbd_pkg::IDX_W;
    localparam int CP_BIT = DUR_LO + mbd_pkg::TIME_W;
    localparam int CR_BIT = CP_BIT + 1;

    // unpack the input transfer
    logic [mbd_pkg::RAW_W-1:0]  raw_bits;
    logic [mbd_pkg::TIME_W-1:0] now_ms;
    logic [mbd_pkg::IDX_W-1:0]  button_index;
    logic [mbd_pkg::TIME_W-1:0] hold_duration;
    logic                       clear_pressed;
    logic                       clear_released;

    assign raw_bits       = s_tdata[mbd_pkg::RAW_W-1:0];
    assign now_ms         = s_tdata[NOW_LO +: mbd_pkg::TIME_W];
    assign button_index   = s_tdata[IDX_LO +: mbd_pkg::IDX_W];
    assign hold_duration  = s_tdata[DUR_LO +: mbd_pkg::TIME_W];
    assign clear_pressed  = s_tdata[CP_BIT];
    assign clear_released = s_tdata[CR_BIT];

    logic s_fire, scan_fire, query_fire, cfg_fire;
    logic merge_ready;

    assign s_tready   = merge_ready;
    assign s_fire     = s_tvalid && s_tready;
    assign scan_fire  = s_fire && (mbd_pkg::op_t'(s_tuser) == mbd_pkg::OP_SCAN);
    assign query_fire = s_fire && (mbd_pkg::op_t'(s_tuser) == mbd_pkg::OP_QUERY);

    // configuration registers; always ready
    logic                           active_low_reg, active_low_next;
    logic [mbd_pkg::OFFSET_W-1:0]   offset_reg, offset_next;
    logic                           init_pulse;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        active_low_next = active_low_reg;
        offset_next     = offset_reg;
        init_pulse      = 1'b0;
        if (cfg_fire) begin
            unique case (mbd_pkg::cfg_reg_t'(cfg_index))
                mbd_pkg::REG_ACTIVE_LOW: begin
                    active_low_next = cfg_data[0];
                    init_pulse      = 1'b1;
                end
                mbd_pkg::REG_BIT_OFFSET: begin
                    offset_next = cfg_data[mbd_pkg::OFFSET_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg <= 1'b1;
            offset_reg     <= '0;
        end else begin
            active_low_reg <= active_low_next;
            offset_reg     <= offset_next;
        end
    end

    // align samples: shifting in zeros makes positions past bit 63 read 0
    logic [mbd_pkg::RAW_W-1:0] aligned;
    assign aligned = raw_bits >> offset_reg;

    // one lane per button
    mbd_pkg::lane_ctrl_t lane_ctrl [mbd_pkg::NUM_BUTTONS];
    mbd_pkg::lane_stat_t lane_stat [mbd_pkg::NUM_BUTTONS];

    for (genvar k = 0; k < mbd_pkg::NUM_BUTTONS; k++) begin : g_lane
        logic hit;
        assign hit = query_fire &&
            (32'(k) == {{(32 - mbd_pkg::IDX_W){1'b0}}, button_index});

        // the user must write config only while idle, so init never meets a transfer; the block does not enforce it
        assign lane_ctrl[k].init        = init_pulse;
        assign lane_ctrl[k].active_low  = init_pulse ? active_low_next : active_low_reg;
        assign lane_ctrl[k].scan_en     = scan_fire;
        assign lane_ctrl[k].sample      = aligned[k];
        assign lane_ctrl[k].now_ms      = now_ms;
        assign lane_ctrl[k].clr_press   = hit && clear_pressed;
        assign lane_ctrl[k].clr_release = hit && clear_released;

        mbd_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl[k]),
            .stat    (lane_stat[k])
        );
    end

    // pick the queried lane, compute hold figures, buffer the result
    mbd_pkg::result_t result;

    mbd_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stat          (lane_stat),
        .query_fire    (query_fire),
        .button_index  (button_index),
        .now_ms        (now_ms),
        .hold_duration (hold_duration),
        .in_ready      (merge_ready),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_result    (result)
    );

    assign m_tdata = {{(mbd_pkg::M_TDATA_W - mbd_pkg::M_FIELDS_W){1'b0}}, result};

endmodule

### rtl/mbd_checker.sv
`timescale 1ns / 1ps

module mbd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mbd_pkg::M_TDATA_W-1:0] m_tdata
);

    // no result survives a reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // input back-pressure only while results are waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // long-enough implies held, and a released button reports zero hold time
    a_hold_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] || (!m_tdata[3] && m_tdata[35:4] == '0)))
        else $error("hold fields inconsistent with held");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
